### design/scc_pkg.sv
// Shared types, constants and the scancode lookup for the scancode text console.
package scc_pkg;

    // Fixed field widths
    localparam int IDX_W  = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CMD_W  = 1;
    localparam int CODE_W = 8;
    localparam int PROMPT_W = 64;

    // Prompt is eight characters; backspace never erases into it
    localparam int PROMPT_LEN = 8;
    localparam int CNT_W      = $clog2(PROMPT_LEN);

    // Defaults for top-level parameters
    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_ROWS        = 25;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROMPT_TEXT = 2'd1;

    localparam logic [ATTR_W-1:0]   TEXT_COLOUR_RST = 8'h6E;
    localparam logic [PROMPT_W-1:0] PROMPT_TEXT_RST = '0;

    // Scancodes with special handling
    localparam logic [CODE_W-1:0] SC_ENTER = 8'h1C;
    localparam logic [CODE_W-1:0] SC_BKSP  = 8'h0E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Operation codes carried from front to back
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_CHAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENTER  = 2'd1;
    localparam logic [OP_W-1:0] OP_PROMPT = 2'd2;
    localparam logic [OP_W-1:0] OP_BKSP   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
    } op_item_t;

    // Set-1 make code to ASCII; CH_NONE for codes without a character
    function automatic logic [CHAR_W-1:0] key_map(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            8'h10: ch = "q";
            8'h11: ch = "w";
            8'h12: ch = "e";
            8'h13: ch = "r";
            8'h14: ch = "t";
            8'h15: ch = "y";
            8'h16: ch = "u";
            8'h17: ch = "i";
            8'h18: ch = "o";
            8'h19: ch = "p";
            8'h1E: ch = "a";
            8'h1F: ch = "s";
            8'h20: ch = "d";
            8'h21: ch = "f";
            8'h22: ch = "g";
            8'h23: ch = "h";
            8'h24: ch = "j";
            8'h25: ch = "k";
            8'h26: ch = "l";
            8'h2C: ch = "z";
            8'h2D: ch = "x";
            8'h2E: ch = "c";
            8'h2F: ch = "v";
            8'h30: ch = "b";
            8'h31: ch = "n";
            8'h32: ch = "m";
            8'h39: ch = CH_SPACE;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

### design/scancode_text_console.sv
// Scancode text console: set-1 make codes and prompt commands in, text-mode
// cell writes out. Letters a-z and space are written at the cursor, which
// then advances (wrapping at COLUMNS into the next row, and at ROWS back to
// row 0; no scrolling). Enter starts a new line and writes the eight prompt
// characters; a prompt command (cmd=1) writes them at the cursor. Backspace
// erases left of the cursor only past the prompt area (column > 8). Other
// codes, break codes included, are consumed with no output. Each write
// carries cell_index = row*COLUMNS+column (11 bits), the character, the
// current text_colour and the cursor after that write; last marks the final
// write of a transaction. Timing: a letter or backspace yields one write, which
// is held in the executor's output register; Enter and prompt yield eight
// writes in sequence, paced by the executor's single output register
// (one cell write per cycle while m_ready is high). The input side keeps
// accepting one transaction per cycle while the operation queue (QUEUE_DEPTH
// entries) has room, so a burst of keys is taken even while a prompt is
// being written. Configuration writes take effect on the next clock and are
// expected only when the console is idle.
module scancode_text_console #(
    parameter int COLUMNS     = scc_pkg::DEF_COLUMNS,
    parameter int ROWS        = scc_pkg::DEF_ROWS,
    parameter int QUEUE_DEPTH = scc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scc_pkg::PROMPT_W-1:0]      cfg_data,

    // input transactions
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [scc_pkg::CMD_W-1:0]         s_cmd,
    input  logic [scc_pkg::CODE_W-1:0]        s_scancode,

    // cell write transactions
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [scc_pkg::IDX_W-1:0]         m_cell_index,
    output logic [scc_pkg::CHAR_W-1:0]        m_char_code,
    output logic [scc_pkg::ATTR_W-1:0]        m_cell_colour,
    output logic                              m_last,
    output logic [scc_pkg::ROW_W-1:0]         m_cursor_row_out,
    output logic [scc_pkg::COL_W-1:0]         m_cursor_col_out
);

    // configuration registers
    logic [scc_pkg::ATTR_W-1:0]   text_colour_reg;
    logic [scc_pkg::PROMPT_W-1:0] prompt_text_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_colour_reg <= scc_pkg::TEXT_COLOUR_RST;
            prompt_text_reg <= scc_pkg::PROMPT_TEXT_RST;
        end else if (cfg_wr_en) begin
            // indexes beyond the register list are ignored
            if (cfg_index == scc_pkg::REG_TEXT_COLOUR) begin
                text_colour_reg <= cfg_data[scc_pkg::ATTR_W-1:0];
            end else if (cfg_index == scc_pkg::REG_PROMPT_TEXT) begin
                prompt_text_reg <= cfg_data;
            end
        end
    end

    // front -> queue -> back
    logic              q_push, q_pop, q_full, q_empty;
    scc_pkg::op_item_t q_in_item, q_out_item;

    scc_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_scancode (s_scancode),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in_item)
    );

    scc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    scc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .text_colour      (text_colour_reg),
        .prompt_text      (prompt_text_reg),
        .q_empty          (q_empty),
        .q_item           (q_out_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_index     (m_cell_index),
        .m_char_code      (m_char_code),
        .m_cell_colour    (m_cell_colour),
        .m_last           (m_last),
        .m_cursor_row_out (m_cursor_row_out),
        .m_cursor_col_out (m_cursor_col_out)
    );

endmodule

### design/scc_front.sv
// Input stage: classifies scancodes and commands into queued operations.
module scc_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [scc_pkg::CMD_W-1:0]     s_cmd,
    input  logic [scc_pkg::CODE_W-1:0]    s_scancode,
    input  logic                          q_full,
    output logic                          q_push,
    output scc_pkg::op_item_t             q_item
);

    logic                        keep;
    logic [scc_pkg::CHAR_W-1:0]  key_ch;

    assign key_ch  = scc_pkg::key_map(s_scancode);
    assign s_ready = !q_full;

    always_comb begin
        q_item.op = scc_pkg::OP_CHAR;
        q_item.ch = key_ch;
        keep      = 1'b1;
        priority if (s_cmd[0]) begin
            q_item.op = scc_pkg::OP_PROMPT;
        end else if (s_scancode == scc_pkg::SC_ENTER) begin
            q_item.op = scc_pkg::OP_ENTER;
        end else if (s_scancode == scc_pkg::SC_BKSP) begin
            q_item.op = scc_pkg::OP_BKSP;
        end else if (key_ch != scc_pkg::CH_NONE) begin
            q_item.op = scc_pkg::OP_CHAR;
        end else begin
            // break codes and unmapped keys are dropped here
            keep = 1'b0;
        end
    end

    assign q_push = s_valid && s_ready && keep;

endmodule

### design/scc_queue.sv
// Small FIFO of classified operations between front and back.
module scc_queue #(
    parameter int DEPTH = scc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  scc_pkg::op_item_t push_item,
    output logic              full,
    input  logic              pop,
    output scc_pkg::op_item_t pop_item,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scc_pkg::op_item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/scc_back.sv
// Execution stage: owns the cursor and emits one cell write per cycle while m_ready does not stall it.
module scc_back #(
    parameter int COLUMNS = scc_pkg::DEF_COLUMNS,
    parameter int ROWS    = scc_pkg::DEF_ROWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [scc_pkg::ATTR_W-1:0]     text_colour,
    input  logic [scc_pkg::PROMPT_W-1:0]   prompt_text,
    input  logic                           q_empty,
    input  scc_pkg::op_item_t              q_item,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [scc_pkg::IDX_W-1:0]      m_cell_index,
    output logic [scc_pkg::CHAR_W-1:0]     m_char_code,
    output logic [scc_pkg::ATTR_W-1:0]     m_cell_colour,
    output logic                           m_last,
    output logic [scc_pkg::ROW_W-1:0]      m_cursor_row_out,
    output logic [scc_pkg::COL_W-1:0]      m_cursor_col_out
);

    localparam int RW = scc_pkg::ROW_W;
    localparam int CW = scc_pkg::COL_W;
    localparam int PW = RW + CW;   // product width, row*COLUMNS+col never overflows

    logic [RW-1:0]               row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic                        busy_reg, busy_next;
    logic [scc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic                        m_valid_reg;
    logic [scc_pkg::IDX_W-1:0]   m_cell_index_reg;
    logic [scc_pkg::CHAR_W-1:0]  m_char_code_reg;
    logic [scc_pkg::ATTR_W-1:0]  m_cell_colour_reg;
    logic                        m_last_reg;
    logic [RW-1:0]               m_row_reg;
    logic [CW-1:0]               m_col_reg;

    logic                        out_free;
    logic                        emit_valid, emit_last, do_adv;
    logic [RW-1:0]               emit_row;
    logic [CW-1:0]               emit_col;
    logic [scc_pkg::CHAR_W-1:0]  emit_ch;
    logic [CW:0]                 col_p1;
    logic [PW-1:0]               addr;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        logic [RW:0] r1;
        r1 = {1'b0, r} + 1'b1;
        return (r1 >= (RW+1)'(ROWS)) ? '0 : r1[RW-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = out_free && !busy_reg && !q_empty;

    always_comb begin
        emit_valid = 1'b0;
        emit_last  = 1'b0;
        do_adv     = 1'b0;
        emit_row   = row_reg;
        emit_col   = col_reg;
        emit_ch    = scc_pkg::CH_SPACE;
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        if (out_free) begin
            if (busy_reg) begin
                // remaining prompt characters
                emit_valid = 1'b1;
                do_adv     = 1'b1;
                emit_ch    = prompt_text[{cnt_reg, 3'b000} +: scc_pkg::CHAR_W];
                emit_last  = (cnt_reg == scc_pkg::CNT_W'(scc_pkg::PROMPT_LEN - 1));
                cnt_next   = cnt_reg + 1'b1;
                busy_next  = !emit_last;
            end else if (!q_empty) begin
                unique case (q_item.op)
                    scc_pkg::OP_CHAR: begin
                        emit_valid = 1'b1;
                        do_adv     = 1'b1;
                        emit_last  = 1'b1;
                        emit_ch    = q_item.ch;
                    end
                    scc_pkg::OP_ENTER, scc_pkg::OP_PROMPT: begin
                        if (q_item.op == scc_pkg::OP_ENTER) begin
                            emit_row = row_inc(row_reg);
                            emit_col = '0;
                        end
                        // first prompt character goes out now
                        emit_valid = 1'b1;
                        do_adv     = 1'b1;
                        emit_ch    = prompt_text[scc_pkg::CHAR_W-1:0];
                        cnt_next   = scc_pkg::CNT_W'(1);
                        busy_next  = 1'b1;
                    end
                    scc_pkg::OP_BKSP: begin
                        if (col_reg > CW'(scc_pkg::PROMPT_LEN)) begin
                            emit_valid = 1'b1;
                            emit_last  = 1'b1;
                            emit_col   = col_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // cursor after this write
    assign col_p1 = {1'b0, emit_col} + 1'b1;
    always_comb begin
        row_next = emit_row;
        col_next = emit_col;
        if (do_adv) begin
            if (col_p1 >= (CW+1)'(COLUMNS)) begin
                col_next = '0;
                row_next = row_inc(emit_row);
            end else begin
                col_next = col_p1[CW-1:0];
            end
        end
    end

    assign addr = PW'(emit_row) * PW'(COLUMNS) + PW'(emit_col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (emit_valid) begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            m_cell_index_reg  <= addr[scc_pkg::IDX_W-1:0];
            m_char_code_reg   <= emit_ch;
            m_cell_colour_reg <= text_colour;
            m_last_reg        <= emit_last;
            m_row_reg         <= row_next;
            m_col_reg         <= col_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cell_index     = m_cell_index_reg;
    assign m_char_code      = m_char_code_reg;
    assign m_cell_colour    = m_cell_colour_reg;
    assign m_last           = m_last_reg;
    assign m_cursor_row_out = m_row_reg;
    assign m_cursor_col_out = m_col_reg;

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, col_reg} < (CW+1)'(COLUMNS)))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, row_reg} < (RW+1)'(ROWS)))
        else $error("cursor row out of range");

    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0))
        else $error("prompt sequencer busy with zero count");

    a_nonlast_in_prompt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> busy_reg)
        else $error("non-final write outside a prompt sequence");

endmodule
